// ===== rtl/core/jha_pkg.sv =====
// shared types, constants and register codes for the joint histogram accumulator
`timescale 1ns / 1ps
`default_nettype none

package jha_pkg;

    localparam int BINS_DEFAULT        = 256;
    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int SAMPLE_W            = 16;
    localparam int INDEX_W             = 8;
    localparam int OUT_W               = 32;
    localparam int CFG_INDEX_W         = 4;
    localparam int CFG_DATA_W          = 16;
    localparam int DIV_STEPS           = SAMPLE_W;
    localparam int STEP_W              = $clog2(DIV_STEPS);

    localparam logic KIND_ACCUM = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIGIN_A     = 4'd0,
        REG_ORIGIN_B     = 4'd1,
        REG_WIDTH_A      = 4'd2,
        REG_WIDTH_B      = 4'd3,
        REG_CLAMP_LOW_A  = 4'd4,
        REG_CLAMP_HIGH_A = 4'd5,
        REG_CLAMP_LOW_B  = 4'd6,
        REG_CLAMP_HIGH_B = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic prep;
        logic div_step;
        logic addr;
        logic read;
        logic update;
        logic emit;
    } jha_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic div_last;
        logic out_free;
    } jha_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/joint_histogram_accumulator_top.sv =====
// top level of the joint histogram accumulator
// an accumulate request steps through prep, the 16-step bin divider, address, read, update
// and emit; a read request skips the divider; a new request waits until the last is emitted
// the result register lets a new request be accepted while a result waits to be taken
// after reset the count store is cleared one entry per cycle, all BINS_PER_AXIS^2 entries,
// with no request accepted meanwhile; configuration resets to its defaults at once
`timescale 1ns / 1ps
`default_nettype none

module joint_histogram_accumulator_top
    import jha_pkg::*;
#(
    parameter int BINS_PER_AXIS = BINS_DEFAULT,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire logic                       kind,
    input  wire logic signed [SAMPLE_W-1:0] sample_a,
    input  wire logic signed [SAMPLE_W-1:0] sample_b,
    input  wire logic [INDEX_W-1:0]         read_column,
    input  wire logic [INDEX_W-1:0]         read_row,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output logic                            in_range,
    output logic [OUT_W-1:0]                bin_count,
    output logic [OUT_W-1:0]                peak_count,
    output logic                            count_overflow
);

    jha_cmd_t    cmd;
    jha_status_t status;

    jha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    jha_datapath #(
        .BINS_PER_AXIS (BINS_PER_AXIS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .sample_a       (sample_a),
        .sample_b       (sample_b),
        .read_column    (read_column),
        .read_row       (read_row),
        .cmd            (cmd),
        .status         (status),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .in_range       (in_range),
        .bin_count      (bin_count),
        .peak_count     (peak_count),
        .count_overflow (count_overflow)
    );

endmodule

`default_nettype wire

// ===== rtl/core/jha_ram.sv =====
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module jha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/jha_ctrl.sv =====
// sequencing state machine for the joint histogram accumulator
`timescale 1ns / 1ps
`default_nettype none

module jha_ctrl
    import jha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire jha_status_t status,
    output jha_cmd_t         cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_PREP   = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_ADDR   = 8'b0001_0000,
        S_READ   = 8'b0010_0000,
        S_UPDATE = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
                if (req_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.is_read ? S_ADDR : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/jha_datapath.sv =====
// configuration, clamp and offset, bin dividers, count store and result register
`timescale 1ns / 1ps
`default_nettype none

module jha_datapath
    import jha_pkg::*;
#(
    parameter int BINS_PER_AXIS = BINS_DEFAULT,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       kind,
    input  wire logic signed [SAMPLE_W-1:0] sample_a,
    input  wire logic signed [SAMPLE_W-1:0] sample_b,
    input  wire logic [INDEX_W-1:0]         read_column,
    input  wire logic [INDEX_W-1:0]         read_row,
    input  wire jha_cmd_t                   cmd,
    output jha_status_t                     status,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output logic                            in_range,
    output logic [OUT_W-1:0]                bin_count,
    output logic [OUT_W-1:0]                peak_count,
    output logic                            count_overflow
);

    localparam int DEPTH  = BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int AXIS_W = $clog2(BINS_PER_AXIS);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {COUNT_WIDTH{1'b1}};

    // configuration
    logic signed [SAMPLE_W-1:0] origin_a_reg, origin_b_reg;
    logic [SAMPLE_W-1:0]        width_a_reg, width_b_reg;
    logic signed [SAMPLE_W-1:0] clo_a_reg, chi_a_reg, clo_b_reg, chi_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_a_reg <= '0;
            origin_b_reg <= '0;
            width_a_reg  <= SAMPLE_W'(1);
            width_b_reg  <= SAMPLE_W'(1);
            clo_a_reg    <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            chi_a_reg    <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            clo_b_reg    <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            chi_b_reg    <= {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_A:     origin_a_reg <= cfg_data;
                REG_ORIGIN_B:     origin_b_reg <= cfg_data;
                REG_WIDTH_A:      width_a_reg  <= cfg_data;
                REG_WIDTH_B:      width_b_reg  <= cfg_data;
                REG_CLAMP_LOW_A:  clo_a_reg    <= cfg_data;
                REG_CLAMP_HIGH_A: chi_a_reg    <= cfg_data;
                REG_CLAMP_LOW_B:  clo_b_reg    <= cfg_data;
                REG_CLAMP_HIGH_B: chi_b_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // a zero width behaves as width one
    logic [SAMPLE_W-1:0] wid_a, wid_b;
    assign wid_a = (width_a_reg == '0) ? SAMPLE_W'(1) : width_a_reg;
    assign wid_b = (width_b_reg == '0) ? SAMPLE_W'(1) : width_b_reg;

    // request capture
    logic                       kind_reg;
    logic signed [SAMPLE_W-1:0] samp_a_reg, samp_b_reg;
    logic [INDEX_W-1:0]         rcol_reg, rrow_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            samp_a_reg <= sample_a;
            samp_b_reg <= sample_b;
            rcol_reg   <= read_column;
            rrow_reg   <= read_row;
        end
    end

    // clamp (upper limit first) and offset from origin
    logic signed [SAMPLE_W-1:0] hc_a, hc_b, cl_a, cl_b;
    logic signed [SAMPLE_W:0]   off_a, off_b;
    logic [SAMPLE_W:0]          neg_off_a, neg_off_b;

    always_comb
    begin
        hc_a      = (samp_a_reg > chi_a_reg) ? chi_a_reg : samp_a_reg;
        cl_a      = (hc_a < clo_a_reg) ? clo_a_reg : hc_a;
        hc_b      = (samp_b_reg > chi_b_reg) ? chi_b_reg : samp_b_reg;
        cl_b      = (hc_b < clo_b_reg) ? clo_b_reg : hc_b;
        off_a     = {cl_a[SAMPLE_W-1], cl_a} - {origin_a_reg[SAMPLE_W-1], origin_a_reg};
        off_b     = {cl_b[SAMPLE_W-1], cl_b} - {origin_b_reg[SAMPLE_W-1], origin_b_reg};
        neg_off_a = -off_a;
        neg_off_b = -off_b;
    end

    // restoring dividers, one quotient bit per cycle on both axes
    logic                neg_a_reg, neg_b_reg;
    logic [SAMPLE_W-1:0] quo_a_reg, quo_b_reg, quo_a_next, quo_b_next;
    logic [SAMPLE_W-1:0] rem_a_reg, rem_b_reg, rem_a_next, rem_b_next;
    logic [STEP_W-1:0]   step_reg;
    logic [SAMPLE_W:0]   sh_a, sh_b;
    logic                ge_a, ge_b;

    always_comb
    begin
        sh_a       = {rem_a_reg, quo_a_reg[SAMPLE_W-1]};
        sh_b       = {rem_b_reg, quo_b_reg[SAMPLE_W-1]};
        ge_a       = sh_a >= {1'b0, wid_a};
        ge_b       = sh_b >= {1'b0, wid_b};
        rem_a_next = ge_a ? SAMPLE_W'(sh_a - {1'b0, wid_a}) : sh_a[SAMPLE_W-1:0];
        rem_b_next = ge_b ? SAMPLE_W'(sh_b - {1'b0, wid_b}) : sh_b[SAMPLE_W-1:0];
        quo_a_next = {quo_a_reg[SAMPLE_W-2:0], ge_a};
        quo_b_next = {quo_b_reg[SAMPLE_W-2:0], ge_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.prep)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            neg_a_reg <= off_a[SAMPLE_W];
            neg_b_reg <= off_b[SAMPLE_W];
            quo_a_reg <= off_a[SAMPLE_W] ? neg_off_a[SAMPLE_W-1:0] : off_a[SAMPLE_W-1:0];
            quo_b_reg <= off_b[SAMPLE_W] ? neg_off_b[SAMPLE_W-1:0] : off_b[SAMPLE_W-1:0];
            rem_a_reg <= '0;
            rem_b_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_a_reg <= quo_a_next;
            quo_b_reg <= quo_b_next;
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
        end
    end

    // bin selection; a negative offset only survives when its quotient is zero
    logic              ok_a, ok_b, rd_ok;
    logic              hit_reg, hit_next;
    logic [AXIS_W-1:0] col, row;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    always_comb
    begin
        ok_a  = (!neg_a_reg || quo_a_reg == '0) && (32'(quo_a_reg) < 32'(BINS_PER_AXIS));
        ok_b  = (!neg_b_reg || quo_b_reg == '0) && (32'(quo_b_reg) < 32'(BINS_PER_AXIS));
        rd_ok = (32'(rcol_reg) < 32'(BINS_PER_AXIS)) && (32'(rrow_reg) < 32'(BINS_PER_AXIS));
        if (kind_reg == KIND_READ)
        begin
            hit_next = rd_ok;
            col      = AXIS_W'(rcol_reg);
            row      = AXIS_W'(rrow_reg);
        end
        else
        begin
            hit_next = ok_a && ok_b;
            col      = AXIS_W'(quo_a_reg);
            row      = AXIS_W'(quo_b_reg);
        end
        addr_next = ADDR_W'(ADDR_W'(row) * ADDR_W'(BINS_PER_AXIS)) + ADDR_W'(col);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.addr)
        begin
            hit_reg  <= hit_next;
            addr_reg <= addr_next;
        end
    end

    // count store, cleared one entry per cycle after reset
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [COUNT_WIDTH-1:0] rd_cnt, inc_cnt;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic                   acc_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    assign inc_cnt = (rd_cnt == COUNT_LIMIT) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);
    assign acc_hit = cmd.update && hit_reg && (kind_reg == KIND_ACCUM);
    assign wr_en   = cmd.clear || acc_hit;
    assign wr_addr = cmd.clear ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clear ? '0 : inc_cnt;

    jha_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_counts (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.read),
        .rd_addr (addr_reg),
        .rd_data (rd_cnt)
    );

    // peak and sticky overflow
    logic [COUNT_WIDTH-1:0] peak_reg;
    logic                   ovf_reg;
    logic [COUNT_WIDTH-1:0] stage_cnt_reg, stage_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (acc_hit)
        begin
            if (inc_cnt > peak_reg)
            begin
                peak_reg <= inc_cnt;
            end
            if (inc_cnt == COUNT_LIMIT)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (!hit_reg)
        begin
            stage_cnt_next = '0;
        end
        else if (kind_reg == KIND_READ)
        begin
            stage_cnt_next = rd_cnt;
        end
        else
        begin
            stage_cnt_next = inc_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            stage_cnt_reg <= stage_cnt_next;
        end
    end

    // result register
    logic             res_valid_reg;
    logic             in_range_reg, ovf_out_reg;
    logic [OUT_W-1:0] bin_count_reg, peak_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            in_range_reg  <= hit_reg;
            bin_count_reg <= OUT_W'(stage_cnt_reg);
            peak_out_reg  <= OUT_W'(peak_reg);
            ovf_out_reg   <= ovf_reg;
        end
    end

    assign res_valid      = res_valid_reg;
    assign in_range       = in_range_reg;
    assign bin_count      = bin_count_reg;
    assign peak_count     = peak_out_reg;
    assign count_overflow = ovf_out_reg;

    always_comb
    begin
        status.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
        status.is_read    = (kind_reg == KIND_READ);
        status.div_last   = (step_reg == STEP_W'(DIV_STEPS - 1));
        status.out_free   = !res_valid_reg || res_ready;
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench for the joint histogram accumulator: random and directed requests
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import jha_pkg::*;

    localparam int BINS      = BINS_DEFAULT;
    localparam int GRID_AW   = $clog2(BINS * BINS);
    localparam int CFG_REGS  = 8;
    localparam int CFG_SLOTS = 1 << CFG_INDEX_W;
    localparam int CHUNK_LEN = 72;
    localparam logic [OUT_W-1:0] COUNT_MAX = '1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
        logic [INDEX_W-1:0]  read_column;
        logic [INDEX_W-1:0]  read_row;
    } hist_req_t;

    typedef struct packed {
        logic             in_range;
        logic [OUT_W-1:0] bin_count;
        logic [OUT_W-1:0] peak_count;
        logic             count_overflow;
    } hist_res_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index   = '0;
    logic [CFG_DATA_W-1:0]      cfg_data    = '0;
    logic                       req_valid   = 1'b0;
    logic                       req_ready;
    logic                       kind        = KIND_ACCUM;
    logic signed [SAMPLE_W-1:0] sample_a    = '0;
    logic signed [SAMPLE_W-1:0] sample_b    = '0;
    logic [INDEX_W-1:0]         read_column = '0;
    logic [INDEX_W-1:0]         read_row    = '0;
    logic                       res_valid;
    logic                       res_ready   = 1'b0;
    logic                       in_range;
    logic [OUT_W-1:0]           bin_count;
    logic [OUT_W-1:0]           peak_count;
    logic                       count_overflow;

    // histogram model state and register copy
    bit   [OUT_W-1:0]      grid_counts [BINS*BINS];
    bit   [OUT_W-1:0]      peak_model;
    bit                    overflow_model;
    logic [CFG_DATA_W-1:0] reg_file [CFG_SLOTS];

    hist_req_t pending_reqs[$];
    hist_req_t hot_pairs[$];
    hist_res_t expected_results[$];
    hist_req_t held_req;

    int reqs_queued    = 0;
    int reqs_accepted  = 0;
    int fail_count     = 0;
    int pairs_counted  = 0;
    int pairs_dropped  = 0;
    int bins_read      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    joint_histogram_accumulator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .kind           (kind),
        .sample_a       (sample_a),
        .sample_b       (sample_b),
        .read_column    (read_column),
        .read_row       (read_row),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .in_range       (in_range),
        .bin_count      (bin_count),
        .peak_count     (peak_count),
        .count_overflow (count_overflow)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // clamp, offset from origin and divide toward zero; -1 when off the grid
    function automatic int axis_bin(logic [15:0] sample, logic [15:0] lo, logic [15:0] hi,
                                    logic [15:0] origin, logic [15:0] width);
        int v;
        int w;
        int q;
        v = $signed(sample);
        w = (width == 0) ? 1 : int'(width);
        if (v > $signed(hi))
            v = $signed(hi);
        if (v < $signed(lo))
            v = $signed(lo);
        q = (v - $signed(origin)) / w;
        if (q < 0 || q >= BINS)
            return -1;
        return q;
    endfunction

    function automatic int column_of(logic [15:0] sample);
        return axis_bin(sample, reg_file[REG_CLAMP_LOW_A], reg_file[REG_CLAMP_HIGH_A],
                        reg_file[REG_ORIGIN_A], reg_file[REG_WIDTH_A]);
    endfunction

    function automatic int row_of(logic [15:0] sample);
        return axis_bin(sample, reg_file[REG_CLAMP_LOW_B], reg_file[REG_CLAMP_HIGH_B],
                        reg_file[REG_ORIGIN_B], reg_file[REG_WIDTH_B]);
    endfunction

    task automatic update_histogram(input hist_req_t r);
        hist_res_t e;
        int col;
        int row;
        logic [GRID_AW-1:0] bin_idx;
        e = '0;
        if (r.kind == KIND_READ)
        begin
            e.in_range  = 1'b1;
            e.bin_count = grid_counts[GRID_AW'(int'(r.read_row) * BINS + int'(r.read_column))];
            bins_read++;
        end
        else
        begin
            col = column_of(r.sample_a);
            row = row_of(r.sample_b);
            if (col >= 0 && row >= 0)
            begin
                bin_idx = GRID_AW'(row * BINS + col);
                if (grid_counts[bin_idx] != COUNT_MAX)
                    grid_counts[bin_idx]++;
                if (grid_counts[bin_idx] == COUNT_MAX)
                    overflow_model = 1'b1;
                if (grid_counts[bin_idx] > peak_model)
                    peak_model = grid_counts[bin_idx];
                e.in_range  = 1'b1;
                e.bin_count = grid_counts[bin_idx];
                pairs_counted++;
            end
            else
                pairs_dropped++;
        end
        e.peak_count     = peak_model;
        e.count_overflow = overflow_model;
        expected_results.push_back(e);
    endtask

    // value spread over the grid span of one axis plus a little either side
    function automatic logic [15:0] near_grid(logic [15:0] origin, logic [15:0] width);
        int w;
        int v;
        w = (width == 0) ? 1 : int'(width);
        v = $signed(origin) + int'($urandom_range(258 * w)) - 2 * w;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic hist_req_t random_req();
        hist_req_t r;
        hist_req_t h;
        int sel;
        int col;
        int row;
        r.kind        = KIND_ACCUM;
        r.sample_a    = SAMPLE_W'($urandom);
        r.sample_b    = SAMPLE_W'($urandom);
        r.read_column = INDEX_W'($urandom);
        r.read_row    = INDEX_W'($urandom);
        sel = $urandom_range(99);
        if (sel < 20)
        begin
            r.kind = KIND_READ;
            // half the reads look at a bin that is being filled
            if (hot_pairs.size() > 0 && $urandom_range(1) == 1)
            begin
                h = hot_pairs[$urandom_range(hot_pairs.size() - 1)];
                col = column_of(h.sample_a);
                row = row_of(h.sample_b);
                if (col >= 0 && row >= 0)
                begin
                    r.read_column = col[INDEX_W-1:0];
                    r.read_row    = row[INDEX_W-1:0];
                end
            end
        end
        else if (sel < 35)
        begin
            // full-range noise, mostly dropped
        end
        else if (sel < 60 && hot_pairs.size() > 0)
        begin
            h = hot_pairs[$urandom_range(hot_pairs.size() - 1)];
            r.sample_a = h.sample_a;
            r.sample_b = h.sample_b;
        end
        else
        begin
            r.sample_a = near_grid(reg_file[REG_ORIGIN_A], reg_file[REG_WIDTH_A]);
            r.sample_b = near_grid(reg_file[REG_ORIGIN_B], reg_file[REG_WIDTH_B]);
            if (hot_pairs.size() < 6)
                hot_pairs.push_back(r);
        end
        return r;
    endfunction

    task automatic queue_req(input hist_req_t r);
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic queue_accum(input logic [15:0] a, input logic [15:0] b);
        hist_req_t r;
        r             = random_req();
        r.kind        = KIND_ACCUM;
        r.sample_a    = a;
        r.sample_b    = b;
        queue_req(r);
    endtask

    task automatic queue_read(input logic [INDEX_W-1:0] col, input logic [INDEX_W-1:0] row);
        hist_req_t r;
        r             = random_req();
        r.kind        = KIND_READ;
        r.read_column = col;
        r.read_row    = row;
        queue_req(r);
    endtask

    task automatic wait_accepted();
        while (reqs_accepted != reqs_queued)
            @(posedge clk);
    endtask

    task automatic wait_results();
        while (reqs_accepted != reqs_queued || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input idle_mode_t m);
        case (m)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = 73;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 73;
            end
            default:
            begin
                send_idle_pct  = 28;
                recv_stall_pct = 28;
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx < CFG_REGS)
            reg_file[idx] = val;
    endtask

    task automatic program_regs(input logic [15:0] org_a, input logic [15:0] org_b,
                                input logic [15:0] wid_a, input logic [15:0] wid_b,
                                input logic [15:0] lo_a, input logic [15:0] hi_a,
                                input logic [15:0] lo_b, input logic [15:0] hi_b);
        write_reg(REG_ORIGIN_A, org_a);
        write_reg(REG_ORIGIN_B, org_b);
        write_reg(REG_WIDTH_A, wid_a);
        write_reg(REG_WIDTH_B, wid_b);
        write_reg(REG_CLAMP_LOW_A, lo_a);
        write_reg(REG_CLAMP_HIGH_A, hi_a);
        write_reg(REG_CLAMP_LOW_B, lo_b);
        write_reg(REG_CLAMP_HIGH_B, hi_b);
        // unmapped indexes must leave the registers alone
        for (int i = CFG_REGS; i < CFG_SLOTS; i++)
            write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        hot_pairs.delete();
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && req_ready)
            begin
                update_histogram(held_req);
                reqs_accepted++;
            end
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    held_req = pending_reqs.pop_front();
                    req_valid   <= 1'b1;
                    kind        <= held_req.kind;
                    sample_a    <= held_req.sample_a;
                    sample_b    <= held_req.sample_b;
                    read_column <= held_req.read_column;
                    read_row    <= held_req.read_row;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        hist_res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (in_range !== want.in_range)
                begin
                    $error("in_range: expected %0d, got %0d", want.in_range, in_range);
                    fail_count++;
                end
                if (bin_count !== want.bin_count)
                begin
                    $error("bin_count: expected %0d, got %0d", want.bin_count, bin_count);
                    fail_count++;
                end
                if (peak_count !== want.peak_count)
                begin
                    $error("peak_count: expected %0d, got %0d", want.peak_count, peak_count);
                    fail_count++;
                end
                if (count_overflow !== want.count_overflow)
                begin
                    $error("count_overflow: expected %0d, got %0d",
                           want.count_overflow, count_overflow);
                    fail_count++;
                end
            end
        end
        res_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        int phase;
        int chunk;
        reg_file[REG_ORIGIN_A]     = 16'h0000;
        reg_file[REG_ORIGIN_B]     = 16'h0000;
        reg_file[REG_WIDTH_A]      = 16'h0001;
        reg_file[REG_WIDTH_B]      = 16'h0001;
        reg_file[REG_CLAMP_LOW_A]  = 16'h8000;
        reg_file[REG_CLAMP_HIGH_A] = 16'h7FFF;
        reg_file[REG_CLAMP_LOW_B]  = 16'h8000;
        reg_file[REG_CLAMP_HIGH_B] = 16'h7FFF;
        set_idling(IDLE_BOTH);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: unit bins from zero
        queue_accum(0, 0);
        queue_accum(0, 0);
        queue_accum(255, 255);
        queue_accum(256, 0);
        queue_accum(0, -1);
        queue_accum(-32768, 32767);
        queue_accum(32767, -32768);
        queue_accum(255, 0);
        queue_read(0, 0);
        queue_read(255, 255);
        queue_read(17, 200);
        queue_read(255, 0);
        wait_results();

        // wide bins on a, zero width and crossed clamps on b
        program_regs(100, -50, 10, 0, -32768, 32767, 100, -100);
        queue_accum(95, 7);
        queue_accum(90, 0);
        queue_accum(2655, -32768);
        queue_accum(2660, 32767);
        queue_accum(-32768, 0);
        queue_read(0, 150);
        queue_read(255, 150);
        wait_results();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: program_regs(0, 0, 1, 1, -32768, 32767, -32768, 32767);
                1: program_regs(-100, 50, 3, 7, -32768, 32767, -32768, 32767);
                2: program_regs(-32768, -32768, 65535, 256, -32768, 32767, -32768, 32767);
                3: program_regs(900, 32600, 0, 0, 1000, -1000, 32600, 32767);
                4: program_regs(0, -5, 1, 2, 10, 20, -10, 600);
                default: program_regs(32512, 32767, 1, 0, -32768, 32767, -32768, 32767);
            endcase
            for (chunk = 0; chunk < 4; chunk++)
            begin
                set_idling(idle_mode_t'((phase + chunk) % 4));
                repeat (CHUNK_LEN) queue_req(random_req());
                wait_accepted();
            end
            // hold the sender until the pipeline has fully drained
            wait_results();
        end

        repeat (60) @(posedge clk);
        $display("ran %0d requests: %0d pairs counted, %0d dropped, %0d bin reads",
                 reqs_accepted, pairs_counted, pairs_dropped, bins_read);
        $display("eight register settings incl. extremes, peak count reached %0d", peak_model);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/jha_pkg.sv
rtl/core/jha_ram.sv
rtl/core/jha_ctrl.sv
rtl/core/jha_datapath.sv
rtl/core/joint_histogram_accumulator_top.sv
test/tb.sv
